// ----- rtl/dlts_pkg.sv -----
// ----------------------------------------------------------------------------
// Delta list task scheduler package
// Shared types, codes and sizes for the controller and the datapath.
// ----------------------------------------------------------------------------
package dlts_pkg;

	localparam int QueueDepth    = 64;
	localparam logic [7:0] TickReset = 8'd10;

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_DISPATCH = 2'd2,
		CMD_DELETE   = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_SLOT = 2'd2,
		ST_NONE     = 2'd3
	} stat_t;

	// One queue entry as it sits in the entry memory.
	typedef struct packed {
		logic [7:0]  handle;
		logic [31:0] delta;
		logic [31:0] period;
		logic [7:0]  run_count;
	} entry_t;

	// Datapath operations, one per cycle.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LATCH,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_WALK_INIT,
		OP_READ_CUR,
		OP_READ_HEAD,
		OP_READ_PREV,
		OP_READ_NEXT,
		OP_WALK_EVAL,
		OP_SHIFT_INIT,
		OP_SHIFT_WR,
		OP_WR_NEW,
		OP_TICK_WR,
		OP_DISP,
		OP_DEL_INIT,
		OP_SAVE_DELTA,
		OP_MOVE_DN,
		OP_DEC_CNT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   st_set;
		stat_t  st_val;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic cnt_zero;
		logic div_last;
		logic walk_end;
		logic rd_gt;
		logic at_pos;
		logic head_idle;
		logic slot_bad;
		logic rem_last;
		logic requeue;
	} dp_stat_t;

endpackage

// ----- rtl/delta_list_task_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// Delta list task scheduler
// Timer queue of task entries kept as a sorted delta list in one memory.
// ----------------------------------------------------------------------------
// The block holds up to QUEUE_DEPTH tasks, each with a handle, a delta in
// ticks after the entry ahead of it, a period in milliseconds and a run count.
// It takes one command word at a time and answers each with exactly one result
// word; in_stall stays high from acceptance until that result has been taken.
// An add runs a bit-serial divide of the delay by the tick length, then
// walks the list, where every entry that the walk passes costs one memory
// read and one compare, and then shifts the entries behind the insertion
// point, where every entry moved costs one read and one write through the
// single read and single write port of the entry memory. A dispatch of a
// periodic task then runs the add sequence from its full check on, with
// the period as the delay. The memory needs no clearing pass: only entries
// below the task count are ever read.
// tick_length_ms may be written whenever the block is idle; cfg_ready is
// always high. A tick length of zero divides as one.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_top #(
	parameter int QUEUE_DEPTH = dlts_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  tick_length_ms,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  task_handle,
	input  logic [31:0] delay_ms,
	input  logic [31:0] period_ms,
	input  logic [5:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        run_valid,
	output logic [7:0]  run_handle,
	output logic [1:0]  status,
	output logic [6:0]  task_count
);

	dlts_pkg::dp_cmd_t  dp_cmd;
	dlts_pkg::dp_stat_t dp_stat;

	// Configuration writes are always taken at once.
	assign cfg_ready = 1'b1;

	dlts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	dlts_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (tick_length_ms),
		.task_handle (task_handle),
		.delay_ms    (delay_ms),
		.period_ms   (period_ms),
		.slot        (slot),
		.run_valid   (run_valid),
		.run_handle  (run_handle),
		.status      (status),
		.task_count  (task_count)
	);

endmodule

// ----- rtl/dlts_datapath.sv -----
// ----------------------------------------------------------------------------
// Delta list task scheduler datapath
// Entry memory, divider, walk and shift registers, and result registers.
// ----------------------------------------------------------------------------
module dlts_datapath #(
	parameter int QUEUE_DEPTH = dlts_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dlts_pkg::dp_cmd_t cmd,
	output dlts_pkg::dp_stat_t stat,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	input  logic [7:0]        task_handle,
	input  logic [31:0]       delay_ms,
	input  logic [31:0]       period_ms,
	input  logic [5:0]        slot,
	output logic              run_valid,
	output logic [7:0]        run_handle,
	output logic [1:0]        status,
	output logic [6:0]        task_count
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 6;

	dlts_pkg::entry_t mem [QUEUE_DEPTH];
	dlts_pkg::entry_t rd_q;
	dlts_pkg::entry_t wr_data;
	logic [IW-1:0]    rd_addr;
	logic [IW-1:0]    wr_addr;
	logic             wr_en;

	logic [7:0]  tick_q;
	logic [CW-1:0] cnt_q, idx_q, pos_q;
	logic [7:0]  handle_q;
	logic [31:0] period_q;
	logic [5:0]  slot_q;
	logic [31:0] quo_q;
	logic [8:0]  rem_q;
	logic [4:0]  bit_q;
	logic [31:0] d_q;
	logic [31:0] sdelta_q;
	logic        run_valid_q;
	logic [7:0]  run_handle_q;
	dlts_pkg::stat_t status_q;

	logic [7:0]  divisor;
	logic [8:0]  rem_sh;
	logic [CW:0] idx_p1, pos_p1;
	logic [32:0] fold_sum;
	logic [31:0] tick_delta;

	assign divisor  = (tick_q == 8'd0) ? 8'd1 : tick_q;
	assign rem_sh   = {rem_q[7:0], quo_q[31]};
	assign idx_p1   = {1'b0, idx_q} + 1'b1;
	assign pos_p1   = {1'b0, pos_q} + 1'b1;
	assign fold_sum = {1'b0, rd_q.delta} + {1'b0, sdelta_q};
	assign tick_delta = (rd_q.delta != 32'd0) ? rd_q.delta - 32'd1 : 32'd0;

	always_comb begin
		stat.full      = (cnt_q == CW'(QUEUE_DEPTH));
		stat.cnt_zero  = (cnt_q == '0);
		stat.div_last  = (bit_q == 5'd31);
		stat.walk_end  = (idx_q == cnt_q);
		stat.rd_gt     = (rd_q.delta > d_q);
		stat.at_pos    = (idx_q == pos_q);
		stat.head_idle = (rd_q.run_count == 8'd0);
		stat.slot_bad  = (SW'(slot_q) >= SW'(cnt_q));
		stat.rem_last  = (idx_p1 >= {1'b0, cnt_q});
		stat.requeue   = run_valid_q && (period_q != 32'd0);
	end

	// Read address by operation.
	always_comb begin
		case (cmd.op)
			dlts_pkg::OP_READ_HEAD: rd_addr = '0;
			dlts_pkg::OP_READ_PREV: rd_addr = IW'(idx_q - 1'b1);
			dlts_pkg::OP_READ_NEXT: rd_addr = IW'(idx_p1);
			default:                rd_addr = idx_q[IW-1:0];
		endcase
	end

	// Write port by operation.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_data = rd_q;
		case (cmd.op)
			dlts_pkg::OP_SHIFT_WR: begin
				wr_en = 1'b1;
				if ({1'b0, idx_q} == pos_p1) begin
					wr_data.delta = rd_q.delta - d_q;
				end
			end
			dlts_pkg::OP_WR_NEW: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[IW-1:0];
				wr_data = '{handle: handle_q, delta: d_q, period: period_q, run_count: 8'd0};
			end
			dlts_pkg::OP_TICK_WR: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data.delta = tick_delta;
				if (tick_delta == 32'd0 && rd_q.run_count != 8'd255) begin
					wr_data.run_count = rd_q.run_count + 8'd1;
				end
			end
			dlts_pkg::OP_MOVE_DN: begin
				wr_en = 1'b1;
				if (idx_q == pos_q) begin
					wr_data.delta = fold_sum[32] ? 32'hFFFF_FFFF : fold_sum[31:0];
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.op == dlts_pkg::OP_READ_CUR || cmd.op == dlts_pkg::OP_READ_HEAD ||
		    cmd.op == dlts_pkg::OP_READ_PREV || cmd.op == dlts_pkg::OP_READ_NEXT) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= dlts_pkg::TickReset;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				tick_q <= cfg_data;
			end
			if (cmd.op == dlts_pkg::OP_WR_NEW) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.op == dlts_pkg::OP_DEC_CNT) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.st_set) begin
			status_q <= cmd.st_val;
		end
		case (cmd.op)
			dlts_pkg::OP_LATCH: begin
				handle_q    <= task_handle;
				quo_q       <= delay_ms;
				period_q    <= period_ms;
				slot_q      <= slot;
				run_valid_q <= 1'b0;
				run_handle_q <= 8'd0;
				status_q    <= dlts_pkg::ST_OK;
			end
			dlts_pkg::OP_DIV_INIT: begin
				rem_q <= '0;
				bit_q <= '0;
			end
			dlts_pkg::OP_DIV_STEP: begin
				// Restoring division, one quotient bit per cycle.
				if (rem_sh >= {1'b0, divisor}) begin
					rem_q <= rem_sh - {1'b0, divisor};
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[30:0], 1'b0};
				end
				bit_q <= bit_q + 5'd1;
			end
			dlts_pkg::OP_WALK_INIT: begin
				d_q   <= quo_q;
				idx_q <= '0;
				pos_q <= cnt_q;
			end
			dlts_pkg::OP_WALK_EVAL: begin
				if (rd_q.delta > d_q) begin
					pos_q <= idx_q;
				end else begin
					d_q   <= d_q - rd_q.delta;
					idx_q <= idx_q + 1'b1;
				end
			end
			dlts_pkg::OP_SHIFT_INIT: begin
				idx_q <= cnt_q;
			end
			dlts_pkg::OP_SHIFT_WR: begin
				idx_q <= idx_q - 1'b1;
			end
			dlts_pkg::OP_DISP: begin
				run_valid_q  <= 1'b1;
				run_handle_q <= rd_q.handle;
				handle_q     <= rd_q.handle;
				quo_q        <= rd_q.period;
				period_q     <= rd_q.period;
				idx_q        <= '0;
				pos_q        <= '0;
			end
			dlts_pkg::OP_DEL_INIT: begin
				idx_q <= CW'(slot_q);
				pos_q <= CW'(slot_q);
			end
			dlts_pkg::OP_SAVE_DELTA: begin
				sdelta_q <= rd_q.delta;
			end
			dlts_pkg::OP_MOVE_DN: begin
				idx_q <= idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign run_valid  = run_valid_q;
	assign run_handle = run_handle_q;
	assign status     = status_q;
	assign task_count = 7'(cnt_q);

endmodule

// ----- rtl/dlts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Delta list task scheduler controller
// Sequences one command word at a time through the datapath.
// ----------------------------------------------------------------------------
module dlts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	output logic               out_valid,
	input  logic               out_stall,
	output dlts_pkg::dp_cmd_t  cmd,
	input  dlts_pkg::dp_stat_t stat
);

	typedef enum logic [17:0] {
		S_IDLE       = 18'h00001,
		S_ADD_CHK    = 18'h00002,
		S_DIV        = 18'h00004,
		S_WALK_INIT  = 18'h00008,
		S_WALK_CHK   = 18'h00010,
		S_WALK_EVAL  = 18'h00020,
		S_SHIFT_INIT = 18'h00040,
		S_SHIFT_CHK  = 18'h00080,
		S_SHIFT_WR   = 18'h00100,
		S_TICK_RD    = 18'h00200,
		S_TICK_WR    = 18'h00400,
		S_DISP_RD    = 18'h00800,
		S_DISP_CHK   = 18'h01000,
		S_DEL_CHK    = 18'h02000,
		S_REM_RD     = 18'h04000,
		S_REM_SAVE   = 18'h08000,
		S_REM_CHK    = 18'h10000,
		S_REM_WR     = 18'h20000
	} state_t;

	// The result-holding state is kept as its own flag so that the one-hot
	// vector above stays within the working states.
	state_t state_q, state_d;
	logic   done_q, done_d;

	assign in_stall  = !(state_q == S_IDLE && !done_q);
	assign out_valid = done_q;

	always_comb begin
		state_d    = state_q;
		done_d     = done_q;
		cmd.op     = dlts_pkg::OP_NOP;
		cmd.st_set = 1'b0;
		cmd.st_val = dlts_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (done_q) begin
					if (!out_stall) begin
						done_d = 1'b0;
					end
				end else if (in_valid) begin
					cmd.op = dlts_pkg::OP_LATCH;
					case (dlts_pkg::cmd_t'(command))
						dlts_pkg::CMD_ADD:      state_d = S_ADD_CHK;
						dlts_pkg::CMD_TICK:     state_d = S_TICK_RD;
						dlts_pkg::CMD_DISPATCH: state_d = S_DISP_RD;
						default:                state_d = S_DEL_CHK;
					endcase
				end
			end
			S_ADD_CHK: begin
				if (stat.full) begin
					cmd.st_set = 1'b1;
					cmd.st_val = dlts_pkg::ST_FULL;
					state_d    = S_IDLE;
					done_d     = 1'b1;
				end else begin
					cmd.op  = dlts_pkg::OP_DIV_INIT;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = dlts_pkg::OP_DIV_STEP;
				if (stat.div_last) begin
					state_d = S_WALK_INIT;
				end
			end
			S_WALK_INIT: begin
				cmd.op  = dlts_pkg::OP_WALK_INIT;
				state_d = S_WALK_CHK;
			end
			S_WALK_CHK: begin
				if (stat.walk_end) begin
					state_d = S_SHIFT_INIT;
				end else begin
					cmd.op  = dlts_pkg::OP_READ_CUR;
					state_d = S_WALK_EVAL;
				end
			end
			S_WALK_EVAL: begin
				cmd.op  = dlts_pkg::OP_WALK_EVAL;
				state_d = stat.rd_gt ? S_SHIFT_INIT : S_WALK_CHK;
			end
			S_SHIFT_INIT: begin
				cmd.op  = dlts_pkg::OP_SHIFT_INIT;
				state_d = S_SHIFT_CHK;
			end
			S_SHIFT_CHK: begin
				if (stat.at_pos) begin
					cmd.op  = dlts_pkg::OP_WR_NEW;
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					cmd.op  = dlts_pkg::OP_READ_PREV;
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.op  = dlts_pkg::OP_SHIFT_WR;
				state_d = S_SHIFT_CHK;
			end
			S_TICK_RD: begin
				if (stat.cnt_zero) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					cmd.op  = dlts_pkg::OP_READ_HEAD;
					state_d = S_TICK_WR;
				end
			end
			S_TICK_WR: begin
				cmd.op  = dlts_pkg::OP_TICK_WR;
				state_d = S_IDLE;
				done_d  = 1'b1;
			end
			S_DISP_RD: begin
				if (stat.cnt_zero) begin
					cmd.st_set = 1'b1;
					cmd.st_val = dlts_pkg::ST_NONE;
					state_d    = S_IDLE;
					done_d     = 1'b1;
				end else begin
					cmd.op  = dlts_pkg::OP_READ_HEAD;
					state_d = S_DISP_CHK;
				end
			end
			S_DISP_CHK: begin
				if (stat.head_idle) begin
					cmd.st_set = 1'b1;
					cmd.st_val = dlts_pkg::ST_NONE;
					state_d    = S_IDLE;
					done_d     = 1'b1;
				end else begin
					cmd.op  = dlts_pkg::OP_DISP;
					state_d = S_REM_RD;
				end
			end
			S_DEL_CHK: begin
				if (stat.slot_bad) begin
					cmd.st_set = 1'b1;
					cmd.st_val = dlts_pkg::ST_BAD_SLOT;
					state_d    = S_IDLE;
					done_d     = 1'b1;
				end else begin
					cmd.op  = dlts_pkg::OP_DEL_INIT;
					state_d = S_REM_RD;
				end
			end
			S_REM_RD: begin
				cmd.op  = dlts_pkg::OP_READ_CUR;
				state_d = S_REM_SAVE;
			end
			S_REM_SAVE: begin
				cmd.op  = dlts_pkg::OP_SAVE_DELTA;
				state_d = S_REM_CHK;
			end
			S_REM_CHK: begin
				if (stat.rem_last) begin
					cmd.op = dlts_pkg::OP_DEC_CNT;
					if (stat.requeue) begin
						state_d = S_ADD_CHK;
					end else begin
						state_d = S_IDLE;
						done_d  = 1'b1;
					end
				end else begin
					cmd.op  = dlts_pkg::OP_READ_NEXT;
					state_d = S_REM_WR;
				end
			end
			S_REM_WR: begin
				cmd.op  = dlts_pkg::OP_MOVE_DN;
				state_d = S_REM_CHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

endmodule
